>>> rtl/core/odf_pkg.sv
// Package for the observation dedupe filter: widths, register indexes,
// reset values, item and table entry types, and the sequencer states.
// No dependencies; every other file of the block imports it.
`default_nettype none

package odf_pkg;

    // Table depth default and the widths that follow from the item format.
    localparam int ENTRIES_DEF = 8;
    localparam int SLOT_W      = 6;
    localparam int TIME_W      = 32;
    localparam int BAND_W      = 8;
    localparam int FREQ_W      = 16;
    localparam int STR_W       = 8;
    localparam int LAT_W       = 25;
    localparam int LON_W       = 26;
    localparam int LOC_TOL_W   = 26;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_TOL      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STR_TOL       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOC_TOL       = 2'd3;

    localparam logic [TIME_W-1:0]    RST_REPEAT_WINDOW = 32'd15000;
    localparam logic [FREQ_W-1:0]    RST_FREQ_TOL      = 16'd5;
    localparam logic [STR_W-1:0]     RST_STR_TOL       = 8'd1;
    localparam logic [LOC_TOL_W-1:0] RST_LOC_TOL       = 26'd25;

    // Input item code for the mode field.
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic [TIME_W-1:0]       timestamp_ms;
        logic [BAND_W-1:0]       band_code;
        logic [FREQ_W-1:0]       frequency_mhz;
        logic [STR_W-1:0]        signal_strength;
        logic                    position_valid;
        logic signed [LAT_W-1:0] latitude_e5;
        logic signed [LON_W-1:0] longitude_e5;
    } obs_t;

    typedef struct packed {
        logic [TIME_W-1:0]       time_ms;
        logic [BAND_W-1:0]       band;
        logic [FREQ_W-1:0]       frequency;
        logic [STR_W-1:0]        strength;
        logic                    position_valid;
        logic signed [LAT_W-1:0] latitude;
        logic signed [LON_W-1:0] longitude;
    } entry_t;

    typedef struct packed {
        logic              forward;
        logic              matched;
        logic [SLOT_W-1:0] slot_index;
    } res_t;

    typedef struct packed {
        logic [FREQ_W-1:0]    freq_tol;
        logic [STR_W-1:0]     str_tol;
        logic [LOC_TOL_W-1:0] loc_tol;
    } tol_t;

    // Write and clear strobes from the sequencer to the entry store.
    typedef struct packed {
        logic wr_en;
        logic clr;
    } store_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } odf_state_t;

endpackage

`default_nettype wire

>>> rtl/core/odf_if.sv
// Channel interfaces of the observation dedupe filter: the observation input
// channel and the result output channel, each with valid/ready handshake.
// Depends on odf_pkg for the field widths.
`default_nettype none

interface odf_in_if;
    import odf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [TIME_W-1:0]       timestamp_ms;
    logic [BAND_W-1:0]       band_code;
    logic [FREQ_W-1:0]       frequency_mhz;
    logic [STR_W-1:0]        signal_strength;
    logic                    position_valid;
    logic signed [LAT_W-1:0] latitude_e5;
    logic signed [LON_W-1:0] longitude_e5;

    modport source (
        output valid, mode, timestamp_ms, band_code, frequency_mhz,
               signal_strength, position_valid, latitude_e5, longitude_e5,
        input  ready
    );

    modport sink (
        input  valid, mode, timestamp_ms, band_code, frequency_mhz,
               signal_strength, position_valid, latitude_e5, longitude_e5,
        output ready
    );
endinterface

interface odf_out_if;
    import odf_pkg::*;

    logic              valid;
    logic              ready;
    logic              forward;
    logic              matched;
    logic [SLOT_W-1:0] slot_index;

    modport source (
        output valid, forward, matched, slot_index,
        input  ready
    );

    modport sink (
        input  valid, forward, matched, slot_index,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/odf_store.sv
// Entry store of the observation dedupe filter: the table memory with one
// write port and one registered read port, plus per-entry valid bits.
// Depends on odf_pkg.
`default_nettype none

module odf_store #(
    parameter int ENTRIES = odf_pkg::ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [IDX_W-1:0]    rd_addr,
    input  wire odf_pkg::store_cmd_t cmd,
    input  wire logic [IDX_W-1:0]    wr_addr,
    input  wire odf_pkg::entry_t     wr_data,
    output logic                     rd_valid,
    output odf_pkg::entry_t          rd_data
);
    import odf_pkg::*;

    entry_t             entry_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic               rd_valid_reg;
    entry_t             rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    // A clear drops every valid bit at once; the payload is left as it is.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                valid_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_data  = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/odf_match.sv
// Shared match unit of the observation dedupe filter: compares one table
// entry against the held observation within the configured tolerances.
// Depends on odf_pkg.
`default_nettype none

module odf_match (
    input  wire logic            entry_valid,
    input  wire odf_pkg::entry_t entry,
    input  wire odf_pkg::obs_t   item,
    input  wire odf_pkg::tol_t   tol,
    output logic                 hit
);
    import odf_pkg::*;

    logic [FREQ_W:0]  freq_diff;
    logic [FREQ_W:0]  freq_abs;
    logic [STR_W:0]   str_diff;
    logic [STR_W:0]   str_abs;
    logic [LAT_W:0]   lat_diff;
    logic [LAT_W:0]   lat_abs;
    logic [LON_W:0]   lon_diff;
    logic [LON_W:0]   lon_abs;
    logic             freq_ok;
    logic             str_ok;
    logic             pos_ok;

    // Differences are one bit wider than the operands, so they never wrap.
    always_comb
    begin
        freq_diff = {1'b0, entry.frequency} - {1'b0, item.frequency_mhz};
        freq_abs  = freq_diff[FREQ_W] ? (~freq_diff + 1'b1) : freq_diff;
        str_diff  = {1'b0, entry.strength} - {1'b0, item.signal_strength};
        str_abs   = str_diff[STR_W] ? (~str_diff + 1'b1) : str_diff;
        lat_diff  = {entry.latitude[LAT_W-1], entry.latitude}
                  - {item.latitude_e5[LAT_W-1], item.latitude_e5};
        lat_abs   = lat_diff[LAT_W] ? (~lat_diff + 1'b1) : lat_diff;
        lon_diff  = {entry.longitude[LON_W-1], entry.longitude}
                  - {item.longitude_e5[LON_W-1], item.longitude_e5};
        lon_abs   = lon_diff[LON_W] ? (~lon_diff + 1'b1) : lon_diff;

        freq_ok = (freq_abs <= {1'b0, tol.freq_tol});
        str_ok  = (str_abs <= {1'b0, tol.str_tol});
        // Position takes part only when the item carries one.
        pos_ok  = !item.position_valid
               || ((lat_abs <= tol.loc_tol) && (lon_abs <= {1'b0, tol.loc_tol}));

        hit = entry_valid
           && (entry.band == item.band_code)
           && (entry.position_valid == item.position_valid)
           && freq_ok && str_ok && pos_ok;
    end

endmodule

`default_nettype wire

>>> rtl/core/odf_ctrl.sv
// Sequencer of the observation dedupe filter: holds the accepted item, walks
// the table one entry per cycle through the shared match unit, decides pass
// or suppress, updates the store and the replacement pointer, and holds the
// result in an output register. Depends on odf_pkg.
`default_nettype none

module odf_ctrl #(
    parameter int ENTRIES = odf_pkg::ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire odf_pkg::obs_t            in_item,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output odf_pkg::res_t                 out_res,
    input  wire logic [odf_pkg::TIME_W-1:0] repeat_window,
    input  wire logic                     hit,
    input  wire logic [odf_pkg::TIME_W-1:0] rd_time,
    output odf_pkg::obs_t                 item,
    output logic [IDX_W-1:0]              rd_addr,
    output odf_pkg::store_cmd_t           cmd,
    output logic [IDX_W-1:0]              wr_addr,
    output odf_pkg::entry_t               wr_data
);
    import odf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    odf_state_t        state_reg;
    odf_state_t        state_next;
    obs_t              item_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [IDX_W-1:0]  scan_next_idx;
    logic [IDX_W-1:0]  ptr_reg;
    logic [IDX_W-1:0]  ptr_inc;
    logic              hit_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [TIME_W-1:0] hit_time_reg;
    logic              out_valid_reg;
    res_t              res_reg;
    res_t              res_next;
    logic [TIME_W-1:0] elapsed;
    logic              suppress;
    logic              accept;
    logic              fire;
    logic              is_clear;

    assign scan_next_idx = (cmp_idx_reg == LAST_IDX) ? '0 : cmp_idx_reg + 1'b1;
    assign ptr_inc       = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
    assign elapsed       = item_reg.timestamp_ms - hit_time_reg;
    assign suppress      = hit_reg && (elapsed < repeat_window);
    assign is_clear      = (item_reg.mode == MODE_CLEAR);
    assign accept        = in_valid && in_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_item.mode == MODE_CLEAR) ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit || (cmp_idx_reg == LAST_IDX))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready  = 1'b0;
        fire      = 1'b0;
        rd_addr   = scan_next_idx;
        cmd.wr_en = 1'b0;
        cmd.clr   = 1'b0;
        wr_addr   = hit_reg ? slot_reg : ptr_reg;
        res_next  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = '0;
            end
            ST_SCAN:
            begin
            end
            ST_DECIDE:
            begin
                fire = !out_valid_reg || out_ready;
                if (is_clear)
                begin
                    cmd.clr = fire;
                end
                else
                begin
                    cmd.wr_en           = fire && !suppress;
                    res_next.forward    = !suppress;
                    res_next.matched    = hit_reg;
                    res_next.slot_index = SLOT_W'(wr_addr);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        if ((state_reg == ST_SCAN) && hit)
        begin
            slot_reg     <= cmp_idx_reg;
            hit_time_reg <= rd_time;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_idx_reg   <= '0;
            ptr_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cmp_idx_reg <= '0;
                hit_reg     <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                cmp_idx_reg <= scan_next_idx;
                if (hit)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (fire)
            begin
                if (is_clear)
                begin
                    ptr_reg <= '0;
                end
                else if (!hit_reg)
                begin
                    ptr_reg <= ptr_inc;
                end
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign item      = item_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    assign wr_data.time_ms        = item_reg.timestamp_ms;
    assign wr_data.band           = item_reg.band_code;
    assign wr_data.frequency      = item_reg.frequency_mhz;
    assign wr_data.strength       = item_reg.signal_strength;
    assign wr_data.position_valid = item_reg.position_valid;
    assign wr_data.latitude       = item_reg.latitude_e5;
    assign wr_data.longitude      = item_reg.longitude_e5;

endmodule

`default_nettype wire

>>> rtl/core/observation_dedupe_filter_top.sv
// Top level of the observation dedupe filter: configuration registers and
// the wiring of sequencer, shared match unit and entry store.
// Depends on odf_pkg, odf_if, odf_store, odf_match and odf_ctrl.
//
// Usage. Observations enter on the obs channel and one result item leaves on
// the res channel for every accepted item, in order. An item is taken when
// valid and ready are both high at a rising clock edge. Observation items are
// compared with the table entries, lowest index first; a match whose age is
// below the repeat window suppresses the item (forward 0, matched 1), any
// other observation passes and is stored in the matched entry or in the slot
// of the round-robin replacement pointer. A clear item empties the table.
//
// Flow. An observation is accepted in the idle state, walks the table (one
// entry per cycle through the single match unit, stopping at the first hit)
// and is then decided in the decide state; a clear item goes from idle
// straight to the decide state. The block takes one item at a time and
// accepts no new item until the last one is decided. The result sits in an
// output register: the next item is accepted while it waits, and a stalled
// receiver only holds the decision of that next item until the register
// frees.
//
// Reset (rst_n, asynchronous, active low) empties the table, zeroes the
// replacement pointer and loads the default tolerances and window. The
// configuration registers are written through cfg_we, cfg_index, cfg_data;
// the user must write them only while the block is idle (not enforced).
`default_nettype none

module observation_dedupe_filter_top #(
    parameter int ENTRIES = odf_pkg::ENTRIES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    odf_in_if.sink                                obs,
    odf_out_if.source                             res,
    input  wire logic                             cfg_we,
    input  wire logic [odf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [odf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import odf_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Configuration registers.
    logic [TIME_W-1:0]    repeat_window_reg;
    logic [FREQ_W-1:0]    freq_tol_reg;
    logic [STR_W-1:0]     str_tol_reg;
    logic [LOC_TOL_W-1:0] loc_tol_reg;
    tol_t                 tol;

    obs_t             in_item;
    obs_t             item;
    res_t             out_res;
    logic             hit;
    logic             rd_valid;
    entry_t           rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    store_cmd_t       cmd;
    entry_t           wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_window_reg <= RST_REPEAT_WINDOW;
            freq_tol_reg      <= RST_FREQ_TOL;
            str_tol_reg       <= RST_STR_TOL;
            loc_tol_reg       <= RST_LOC_TOL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REPEAT_WINDOW: repeat_window_reg <= cfg_data[TIME_W-1:0];
                REG_FREQ_TOL:      freq_tol_reg      <= cfg_data[FREQ_W-1:0];
                REG_STR_TOL:       str_tol_reg       <= cfg_data[STR_W-1:0];
                REG_LOC_TOL:       loc_tol_reg       <= cfg_data[LOC_TOL_W-1:0];
                default:           repeat_window_reg <= repeat_window_reg;
            endcase
        end
    end

    assign tol.freq_tol = freq_tol_reg;
    assign tol.str_tol  = str_tol_reg;
    assign tol.loc_tol  = loc_tol_reg;

    // Gather the input channel into one item.
    assign in_item.mode            = obs.mode;
    assign in_item.timestamp_ms    = obs.timestamp_ms;
    assign in_item.band_code       = obs.band_code;
    assign in_item.frequency_mhz   = obs.frequency_mhz;
    assign in_item.signal_strength = obs.signal_strength;
    assign in_item.position_valid  = obs.position_valid;
    assign in_item.latitude_e5     = obs.latitude_e5;
    assign in_item.longitude_e5    = obs.longitude_e5;

    odf_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (obs.valid),
        .in_ready      (obs.ready),
        .in_item       (in_item),
        .out_valid     (res.valid),
        .out_ready     (res.ready),
        .out_res       (out_res),
        .repeat_window (repeat_window_reg),
        .hit           (hit),
        .rd_time       (rd_data.time_ms),
        .item          (item),
        .rd_addr       (rd_addr),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    // One entry is compared per cycle, against the store's registered read.
    odf_match u_match (
        .entry_valid (rd_valid),
        .entry       (rd_data),
        .item        (item),
        .tol         (tol),
        .hit         (hit)
    );

    odf_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    assign res.forward    = out_res.forward;
    assign res.matched    = out_res.matched;
    assign res.slot_index = out_res.slot_index;

endmodule

`default_nettype wire

>>> rtl/core/odf_checker.sv
// Port-level checker of the observation dedupe filter, bound to the top.
// Depends on odf_pkg and observation_dedupe_filter_top.
`default_nettype none

module odf_checker #(
    parameter int ENTRIES = odf_pkg::ENTRIES_DEF
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic                        forward,
    input wire logic                        matched,
    input wire logic [odf_pkg::SLOT_W-1:0]  slot_index
);
    import odf_pkg::*;

    // The table walk occupies the block: it is never ready right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    // A result that neither passes nor matched comes only from a clear item, with slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !forward && !matched) |-> (slot_index == '0))
        else $error("clear result with nonzero slot");

    // Every slot reported lies inside the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (slot_index < SLOT_W'(ENTRIES)) || (ENTRIES == 64))
        else $error("slot index beyond table depth");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(forward)
            && $stable(matched) && $stable(slot_index)))
        else $error("stalled result changed");

endmodule

bind observation_dedupe_filter_top odf_checker #(
    .ENTRIES (ENTRIES)
) u_odf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (obs.valid),
    .in_ready   (obs.ready),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .forward    (res.forward),
    .matched    (res.matched),
    .slot_index (res.slot_index)
);

`default_nettype wire
